// ===== src/scs_pkg.sv =====
package scs_pkg;

  localparam int CW = 52;
  localparam int ZW = 34;
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_START_OFS_A = 4'd0;
  localparam logic [CFG_IW-1:0] REG_START_MAG_A = 4'd1;
  localparam logic [CFG_IW-1:0] REG_START_OFS_B = 4'd2;
  localparam logic [CFG_IW-1:0] REG_START_MAG_B = 4'd3;
  localparam logic [CFG_IW-1:0] REG_OFS_GAIN_A  = 4'd4;
  localparam logic [CFG_IW-1:0] REG_MAG_GAIN_A  = 4'd5;
  localparam logic [CFG_IW-1:0] REG_OFS_GAIN_B  = 4'd6;
  localparam logic [CFG_IW-1:0] REG_MAG_GAIN_B  = 4'd7;

  localparam logic [23:0] RST_OFS_A = 24'd1380480;
  localparam logic [23:0] RST_MAG_A = 24'd382080;
  localparam logic [23:0] RST_OFS_B = 24'd1378560;
  localparam logic [23:0] RST_MAG_B = 24'd432640;
  localparam logic [15:0] RST_GAIN  = 16'd3277;

  localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [CW-1:0] KINV    = 52'sd652032874;
  localparam logic [23:0] MAG_MIN = 24'd256;

  typedef enum logic [4:0] {
    S_IDLE, S_MYA, S_MXB, S_VGO, S_VWAIT, S_RGO, S_RWAIT,
    S_MSA, S_MCB, S_MOA, S_MOB, S_MTA, S_MTB, S_MGA, S_MGB, S_FIN, S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctrl_t;

  function automatic logic signed [ZW-1:0] scs_atan(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/scs_in_if.sv =====
interface scs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_a;
  logic [15:0] sample_b;
  modport source (output valid, sample_a, sample_b, input ready);
  modport sink (input valid, sample_a, sample_b, output ready);
endinterface

// ===== src/scs_out_if.sv =====
interface scs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic signed [24:0] error_a;
  logic signed [24:0] error_b;
  logic               magnitude_clamped;
  modport source (output valid, angle, error_a, error_b, magnitude_clamped, input ready);
  modport sink (input valid, angle, error_a, error_b, magnitude_clamped, output ready);
endinterface

// ===== src/sincos_angle_with_adaptive_trim_top.sv =====
// requests are taken one at a time, since one shared cordic unit is
//   run twice per request and one shared multiplier used ten times in sequence
// a new request is taken while the previous result still waits at the output register
// reset (async, active low) loads tracked offsets/magnitudes and gains with their defaults
module sincos_angle_with_adaptive_trim_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scs_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [scs_pkg::CFG_DW-1:0]   cfg_data_i,
  scs_in_if.sink                       in_i,
  scs_out_if.source                    out_o
);
  import scs_pkg::*;

  state_e state_q, state_d;
  cordic_ctrl_t cctl;
  logic cdone;
  logic signed [CW-1:0] cx_i, cy_i, cx_o, cy_o;
  logic signed [ZW-1:0] cz_i, cz_o;

  logic [23:0] oa_q, ob_q, ma_q, mb_q, va_q, vb_q, maw_q, mbw_q;
  logic [15:0] goa_q, gma_q, gob_q, gmb_q;
  logic clamp_q, zero_q;
  logic signed [CW-1:0] y0_q;
  logic signed [15:0] ang_q;
  logic signed [31:0] sn_q, cs_q;
  logic signed [24:0] ea_q, eb_q;
  logic signed [25:0] ta_q, tb_q;
  logic signed [25:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [57:0] p_q, p_r30, p_r16;
  logic signed [24:0] da, db;
  logic signed [CW-1:0] x0;
  logic signed [ZW-1:0] zr, z_r16;
  logic signed [27:0] ea_w, eb_w;
  logic signed [26:0] oa_w, ob_w, ma_w, mb_w;
  logic accept;
  logic ov_q;

  assign accept = in_i.valid && in_i.ready;

  function automatic logic signed [24:0] sat25(input logic signed [27:0] v);
    logic signed [24:0] r;
    if (v > 28'sd16777215) r = 25'sd16777215;
    else if (v < -28'sd16777216) r = -25'sd16777216;
    else r = v[24:0];
    return r;
  endfunction

  function automatic logic [23:0] sat24u(input logic signed [26:0] v);
    logic [23:0] r;
    if (v < 0) r = '0;
    else if (v > 27'sd16777215) r = 24'hFFFFFF;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_one(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > 52'sd1073741824) r = 32'sd1073741824;
    else if (v < -52'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  scs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .ctrl_i(cctl), .x_i(cx_i), .y_i(cy_i), .z_i(cz_i),
    .done_o(cdone), .x_o(cx_o), .y_o(cy_o), .z_o(cz_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cctl = '0;
    in_i.ready = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = S_MYA;
      end
      S_MYA: state_d = S_MXB;
      S_MXB: state_d = S_VGO;
      S_VGO: begin
        cctl.start = 1'b1;
        cctl.vec = 1'b1;
        state_d = S_VWAIT;
      end
      S_VWAIT: if (cdone) state_d = S_RGO;
      S_RGO: begin
        cctl.start = 1'b1;
        state_d = S_RWAIT;
      end
      S_RWAIT: if (cdone) state_d = S_MSA;
      S_MSA: state_d = S_MCB;
      S_MCB: state_d = S_MOA;
      S_MOA: state_d = S_MOB;
      S_MOB: state_d = S_MTA;
      S_MTA: state_d = S_MTB;
      S_MTB: state_d = S_MGA;
      S_MGA: state_d = S_MGB;
      S_MGB: state_d = S_FIN;
      S_FIN: state_d = S_OUT;
      S_OUT: if (!ov_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    da = $signed({1'b0, va_q}) - $signed({1'b0, oa_q});
    db = $signed({1'b0, vb_q}) - $signed({1'b0, ob_q});
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MYA: begin mul_a = 26'(da); mul_b = $signed({8'b0, mbw_q}); end
      S_MXB: begin mul_a = 26'(db); mul_b = $signed({8'b0, maw_q}); end
      S_MSA: begin mul_a = $signed({2'b0, maw_q}); mul_b = sn_q; end
      S_MCB: begin mul_a = $signed({2'b0, mbw_q}); mul_b = cs_q; end
      S_MOA: begin mul_a = 26'(ea_q); mul_b = $signed({16'b0, goa_q}); end
      S_MOB: begin mul_a = 26'(eb_q); mul_b = $signed({16'b0, gob_q}); end
      S_MTA: begin mul_a = 26'(ea_q); mul_b = sn_q; end
      S_MTB: begin mul_a = 26'(eb_q); mul_b = cs_q; end
      S_MGA: begin mul_a = ta_q; mul_b = $signed({16'b0, gma_q}); end
      S_MGB: begin mul_a = tb_q; mul_b = $signed({16'b0, gmb_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    p_r30 = (p_q + 58'sh20000000) >>> 30;
    p_r16 = (p_q + 58'sh8000) >>> 16;
    ea_w = $signed({4'b0, va_q}) - $signed({4'b0, oa_q}) - $signed(p_r30[27:0]);
    eb_w = $signed({4'b0, vb_q}) - $signed({4'b0, ob_q}) - $signed(p_r30[27:0]);
    oa_w = $signed({3'b0, oa_q}) + $signed(p_r16[26:0]);
    ob_w = $signed({3'b0, ob_q}) + $signed(p_r16[26:0]);
    ma_w = $signed({3'b0, maw_q}) + $signed(p_r16[26:0]);
    mb_w = $signed({3'b0, mbw_q}) + $signed(p_r16[26:0]);
    x0 = p_q[CW-1:0];
    z_r16 = (cz_o + 34'sh8000) >>> 16;
    zr = {{2{ang_q[15]}}, ang_q, 16'b0};
    cx_i = x0;
    cy_i = y0_q;
    cz_i = '0;
    if (state_q == S_VGO) begin
      if (x0 < 0) begin
        if (y0_q >= 0) begin
          cx_i = y0_q; cy_i = -x0; cz_i = QUARTER;
        end else begin
          cx_i = -y0_q; cy_i = x0; cz_i = -QUARTER;
        end
      end
    end else begin
      cx_i = KINV; cy_i = '0; cz_i = zr;
      if (zr > QUARTER) begin
        cx_i = '0; cy_i = KINV; cz_i = zr - QUARTER;
      end else if (zr < -QUARTER) begin
        cx_i = '0; cy_i = -KINV; cz_i = zr + QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= 58'(mul_a * mul_b);
    if (accept) begin
      va_q    <= {in_i.sample_a, 8'b0};
      vb_q    <= {in_i.sample_b, 8'b0};
      maw_q   <= (ma_q == '0) ? MAG_MIN : ma_q;
      mbw_q   <= (mb_q == '0) ? MAG_MIN : mb_q;
      clamp_q <= (ma_q == '0) || (mb_q == '0);
    end
    case (state_q)
      S_MXB: y0_q <= p_q[CW-1:0];
      S_VGO: zero_q <= (x0 == '0) && (y0_q == '0);
      S_VWAIT: ang_q <= zero_q ? 16'sd0 : z_r16[15:0];
      S_RWAIT: begin
        cs_q <= sat_one(cx_o);
        sn_q <= sat_one(cy_o);
      end
      S_MCB: ea_q <= sat25(ea_w);
      S_MOA: eb_q <= sat25(eb_w);
      S_MTB: ta_q <= p_r30[25:0];
      S_MGA: tb_q <= p_r30[25:0];
      default: ;
    endcase
  end

  // tracked trims and gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oa_q  <= RST_OFS_A;
      ma_q  <= RST_MAG_A;
      ob_q  <= RST_OFS_B;
      mb_q  <= RST_MAG_B;
      goa_q <= RST_GAIN;
      gma_q <= RST_GAIN;
      gob_q <= RST_GAIN;
      gmb_q <= RST_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_OFS_A: oa_q <= cfg_data_i;
        REG_START_MAG_A: ma_q <= cfg_data_i;
        REG_START_OFS_B: ob_q <= cfg_data_i;
        REG_START_MAG_B: mb_q <= cfg_data_i;
        REG_OFS_GAIN_A:  goa_q <= cfg_data_i[15:0];
        REG_MAG_GAIN_A:  gma_q <= cfg_data_i[15:0];
        REG_OFS_GAIN_B:  gob_q <= cfg_data_i[15:0];
        REG_MAG_GAIN_B:  gmb_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end else begin
      case (state_q)
        S_MOB: oa_q <= sat24u(oa_w);
        S_MTA: ob_q <= sat24u(ob_w);
        S_MGB: ma_q <= sat24u(ma_w);
        S_FIN: mb_q <= sat24u(mb_w);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == S_OUT && (!ov_q || out_o.ready)) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!ov_q || out_o.ready)) begin
      out_o.angle <= ang_q;
      out_o.error_a <= ea_q;
      out_o.error_b <= eb_q;
      out_o.magnitude_clamped <= clamp_q;
    end
  end

  assign out_o.valid = ov_q;

`ifndef SYNTHESIS
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MYA) else $error("accept did not start sequence");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == S_VWAIT || state_q == S_RWAIT)) else $error("stray cordic done");
  a_zero_ang: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RGO && zero_q) |-> ang_q == 16'sd0) else $error("zero vector angle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> $stable(out_o.angle)) else $error("result changed while held");
`endif

endmodule

// ===== src/scs_cordic.sv =====
module scs_cordic #(
  parameter int STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scs_pkg::cordic_ctrl_t      ctrl_i,
  input  logic signed [scs_pkg::CW-1:0] x_i,
  input  logic signed [scs_pkg::CW-1:0] y_i,
  input  logic signed [scs_pkg::ZW-1:0] z_i,
  output logic                       done_o,
  output logic signed [scs_pkg::CW-1:0] x_o,
  output logic signed [scs_pkg::CW-1:0] y_o,
  output logic signed [scs_pkg::ZW-1:0] z_o
);
  import scs_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic          run_q, done_q, vec_q;
  logic [IW-1:0] i_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, a;
  logic          pos;

  always_comb begin
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    a   = scs_atan(5'(i_q));
    pos = vec_q ? !(y_q > 0) : !z_q[ZW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == IW'(STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      vec_q <= ctrl_i.vec;
    end else if (run_q) begin
      if (pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - a;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + a;
      end
    end
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import scs_pkg::*;

  localparam int STEPS = 16;
  localparam int SETTLE = 2 * STEPS + 30;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 92;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 4'd9;
  localparam longint VMAX = 64'sd16777215;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint KINV_Q30 = 64'sd652032874;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [24:0] error_a;
    logic signed [24:0] error_b;
    logic               clamped;
  } trim_result_t;

  typedef struct {
    bit                 is_cfg;
    logic [CFG_IW-1:0]  idx;
    logic [CFG_DW-1:0]  data;
    logic [15:0]        a;
    logic [15:0]        b;
    bit                 fix_angle;
    logic signed [15:0] angle;
    bit                 fix_clamp;
    logic               clamped;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  scs_in_if  in_if();
  scs_out_if out_if();

  sincos_angle_with_adaptive_trim_top #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_if), .out_o(out_if)
  );

  longint atan_q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  longint cfg_reg [8];
  longint ofs_a, mag_a, ofs_b, mag_b;
  trim_result_t result_q [$];
  trim_result_t fixed_q [$];
  bit fixed_angle_q [$];
  bit fixed_clamp_q [$];
  stim_row_t dir_rows [$];
  int fail_cnt;
  int req_cnt;
  int cycle_cnt;
  int hold_cnt;
  bit pressure_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ONE_Q30;
      end else begin
        x = -y; y = t; z = -ONE_Q30;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q32[i];
      end else begin
        x -= ys; y += xs; z -= atan_q32[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate_unit(input longint zin, output longint s, output longint c);
    longint x, y, z, xs, ys;
    x = KINV_Q30; y = 0; z = zin;
    if (z > ONE_Q30) begin
      x = 0; y = KINV_Q30; z -= ONE_Q30;
    end else if (z < -ONE_Q30) begin
      x = 0; y = -KINV_Q30; z += ONE_Q30;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q32[i];
      end else begin
        x += ys; y -= xs; z += atan_q32[i];
      end
    end
    c = clip(x, -ONE_Q30, ONE_Q30);
    s = clip(y, -ONE_Q30, ONE_Q30);
  endfunction

  // computes the result of one request and advances the tracked trims
  function automatic trim_result_t predict_trim(logic [15:0] a, logic [15:0] b);
    trim_result_t r;
    longint va, vb, ma, mb, oa, ob, ang, sn, cs, ea, eb, t;
    va = longint'(a) <<< 8;
    vb = longint'(b) <<< 8;
    ma = mag_a; mb = mag_b; oa = ofs_a; ob = ofs_b;
    r.clamped = 1'b0;
    if (ma <= 0) begin
      ma = 256; r.clamped = 1'b1;
    end
    if (mb <= 0) begin
      mb = 256; r.clamped = 1'b1;
    end
    ang = round_shift(vector_angle((vb - ob) * ma, (va - oa) * mb), 16) & 64'hFFFF;
    if (ang >= 32768) ang -= 65536;
    rotate_unit(ang * 65536, sn, cs);
    ea = clip(va - (oa + round_shift(ma * sn, 30)), -VMAX - 1, VMAX);
    eb = clip(vb - (ob + round_shift(mb * cs, 30)), -VMAX - 1, VMAX);
    ofs_a = clip(oa + round_shift(cfg_reg[REG_OFS_GAIN_A] * ea, 16), 0, VMAX);
    ofs_b = clip(ob + round_shift(cfg_reg[REG_OFS_GAIN_B] * eb, 16), 0, VMAX);
    t = round_shift(ea * sn, 30);
    mag_a = clip(ma + round_shift(cfg_reg[REG_MAG_GAIN_A] * t, 16), 0, VMAX);
    t = round_shift(eb * cs, 30);
    mag_b = clip(mb + round_shift(cfg_reg[REG_MAG_GAIN_B] * t, 16), 0, VMAX);
    r.angle = ang[15:0];
    r.error_a = ea[24:0];
    r.error_b = eb[24:0];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx <= REG_MAG_GAIN_B) begin
      cfg_reg[idx] = idx <= REG_START_MAG_B ? longint'(data) : longint'(data[15:0]);
      case (idx)
        REG_START_OFS_A: ofs_a = cfg_reg[idx];
        REG_START_MAG_A: mag_a = cfg_reg[idx];
        REG_START_OFS_B: ofs_b = cfg_reg[idx];
        REG_START_MAG_B: mag_b = cfg_reg[idx];
        default: ;
      endcase
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_request(logic [15:0] a, logic [15:0] b, int gap,
                              bit fa, bit fc, trim_result_t fx);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample_a <= a;
    in_if.sample_b <= b;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    result_q.push_back(predict_trim(a, b));
    fixed_q.push_back(fx);
    fixed_angle_q.push_back(fa);
    fixed_clamp_q.push_back(fc);
    req_cnt++;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [15:0] to_sample(real v);
    if (v < 0.0) return 16'd0;
    if (v > 65535.0) return 16'hFFFF;
    return 16'(int'(v));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_gain;
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'(RST_GAIN);
      default: return 24'($urandom_range(0, 8000));
    endcase
  endfunction

  function automatic stim_row_t item_row(logic [15:0] a, logic [15:0] b);
    stim_row_t r;
    r = '{default: 0};
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    stim_row_t r;
    r = '{default: 0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  initial begin
    stim_row_t row;
    trim_result_t fx;
    real th, sa, sb;
    int r;
    logic [15:0] a, b;
    bit quiet;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.sample_a = '0;
    in_if.sample_b = '0;
    fail_cnt = 0;
    req_cnt = 0;
    cfg_reg[REG_START_OFS_A] = RST_OFS_A;
    cfg_reg[REG_START_MAG_A] = RST_MAG_A;
    cfg_reg[REG_START_OFS_B] = RST_OFS_B;
    cfg_reg[REG_START_MAG_B] = RST_MAG_B;
    for (int i = REG_OFS_GAIN_A; i <= REG_MAG_GAIN_B; i++) cfg_reg[i] = RST_GAIN;
    ofs_a = RST_OFS_A; mag_a = RST_MAG_A; ofs_b = RST_OFS_B; mag_b = RST_MAG_B;

    dir_rows.push_back(item_row(16'd0, 16'd0));
    dir_rows.push_back(item_row(16'hFFFF, 16'hFFFF));
    dir_rows.push_back(item_row(16'd0, 16'hFFFF));
    dir_rows.push_back(item_row(16'hFFFF, 16'd0));
    dir_rows.push_back(item_row(16'd5392, 16'd5385));
    dir_rows.push_back(item_row(16'd6885, 16'd3695));
    // both channels sit on their offsets
    dir_rows.push_back(cfg_row(REG_START_OFS_A, 24'd256000));
    dir_rows.push_back(cfg_row(REG_START_OFS_B, 24'd512000));
    row = item_row(16'd1000, 16'd2000);
    row.fix_angle = 1'b1; row.angle = 16'sd0;
    row.fix_clamp = 1'b1; row.clamped = 1'b0;
    dir_rows.push_back(row);
    // angle exactly at pi wraps negative
    dir_rows.push_back(cfg_row(REG_START_OFS_A, 24'd256000));
    dir_rows.push_back(cfg_row(REG_START_OFS_B, 24'd512000));
    row = item_row(16'd1000, 16'd0);
    row.fix_angle = 1'b1; row.angle = -16'sd32768;
    dir_rows.push_back(row);
    // zero magnitude on each channel
    dir_rows.push_back(cfg_row(REG_START_MAG_A, 24'd0));
    row = item_row(16'd3000, 16'd500);
    row.fix_clamp = 1'b1; row.clamped = 1'b1;
    dir_rows.push_back(row);
    dir_rows.push_back(cfg_row(REG_START_MAG_A, 24'(RST_MAG_A)));
    dir_rows.push_back(cfg_row(REG_START_MAG_B, 24'd0));
    row = item_row(16'd100, 16'd40000);
    row.fix_clamp = 1'b1; row.clamped = 1'b1;
    dir_rows.push_back(row);
    // saturating errors and trims, masked gains, ignored index
    dir_rows.push_back(cfg_row(REG_START_OFS_A, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(REG_START_MAG_A, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(REG_START_MAG_B, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(REG_OFS_GAIN_A, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(REG_MAG_GAIN_B, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(REG_UNUSED, 24'd12345));
    dir_rows.push_back(item_row(16'd0, 16'hFFFF));
    dir_rows.push_back(item_row(16'hFFFF, 16'd0));
    dir_rows.push_back(item_row(16'd0, 16'd0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i-1].is_cfg) drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        cfg_we_i <= 1'b0;
        fx.angle = dir_rows[i].angle;
        fx.clamped = dir_rows[i].clamped;
        fx.error_a = '0;
        fx.error_b = '0;
        send_request(dir_rows[i].a, dir_rows[i].b, pick_gap(1'b0),
                     dir_rows[i].fix_angle, dir_rows[i].fix_clamp, fx);
      end
    end

    fx = '{default: 0};
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p == 0) begin
        write_reg(REG_START_OFS_A, RST_OFS_A);
        write_reg(REG_START_MAG_A, RST_MAG_A);
        write_reg(REG_START_OFS_B, RST_OFS_B);
        write_reg(REG_START_MAG_B, RST_MAG_B);
        for (int g = REG_OFS_GAIN_A; g <= REG_MAG_GAIN_B; g++)
          write_reg(g[CFG_IW-1:0], 24'(RST_GAIN));
      end else begin
        write_reg(REG_START_OFS_A, 24'($urandom_range(4000, 60000)) << 8);
        write_reg(REG_START_MAG_A, p == N_PHASES - 1 ? 24'hFFFFFF :
                  24'($urandom_range(1, 30000)) << 8);
        write_reg(REG_START_OFS_B, p == 1 ? 24'd0 : 24'($urandom_range(4000, 60000)) << 8);
        write_reg(REG_START_MAG_B, 24'($urandom_range(1, 30000)) << 8);
        for (int g = REG_OFS_GAIN_A; g <= REG_MAG_GAIN_B; g++)
          write_reg(g[CFG_IW-1:0], pick_gain());
      end
      cfg_we_i <= 1'b0;
      quiet = (p % 2) == 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          th = $urandom_range(0, 1000000) * 6.283185307 / 1000000.0;
          sa = cfg_reg[REG_START_OFS_A] / 256.0 +
               cfg_reg[REG_START_MAG_A] / 256.0 * $sin(th) + $urandom_range(0, 40) - 20.0;
          sb = cfg_reg[REG_START_OFS_B] / 256.0 +
               cfg_reg[REG_START_MAG_B] / 256.0 * $cos(th) + $urandom_range(0, 40) - 20.0;
          a = to_sample(sa);
          b = to_sample(sb);
        end else if (r < 92) begin
          a = 16'($urandom);
          b = 16'($urandom);
        end else begin
          a = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
          b = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        end
        send_request(a, b, pick_gap(quiet), 1'b0, 1'b0, fx);
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random holds, one long hold to back up the block
  always @(posedge clk_i or negedge rst_ni) begin
    trim_result_t e, f;
    bit fa, fc;
    int r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt = 0;
      pressure_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          e = result_q.pop_front();
          f = fixed_q.pop_front();
          fa = fixed_angle_q.pop_front();
          fc = fixed_clamp_q.pop_front();
          if (fa) e.angle = f.angle;
          if (fc) e.clamped = f.clamped;
          if (out_if.angle !== e.angle) begin
            $error("angle expected %0d actual %0d", e.angle, out_if.angle);
            fail_cnt++;
          end
          if (out_if.error_a !== e.error_a) begin
            $error("error_a expected %0d actual %0d", e.error_a, out_if.error_a);
            fail_cnt++;
          end
          if (out_if.error_b !== e.error_b) begin
            $error("error_b expected %0d actual %0d", e.error_b, out_if.error_b);
            fail_cnt++;
          end
          if (out_if.magnitude_clamped !== e.clamped) begin
            $error("magnitude_clamped expected %0d actual %0d", e.clamped,
                   out_if.magnitude_clamped);
            fail_cnt++;
          end
        end
      end
      if (!pressure_done && req_cnt >= 150) begin
        pressure_done = 1'b1;
        hold_cnt = 500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (cycle_cnt % 2048 < 512 || r >= 15) begin
          out_if.ready <= 1'b1;
        end else begin
          hold_cnt = r < 2 ? $urandom_range(40, 200) : $urandom_range(0, 5);
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
